@@ rtl/core/stcc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and constants of the servo/throttle command conditioner.
// No dependencies.
package stcc_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int MEDIAN_IDX   = WINDOW_DEPTH / 2;
  localparam int SORT_CNT_W   = $clog2(WINDOW_DEPTH);

  localparam int SAMPLE_W   = 12;
  localparam int CODE_W     = 8;
  localparam int DB_W       = 6;
  localparam int TIMEOUT_W  = 20;
  localparam int TICK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 12'd2048;
  localparam logic [SAMPLE_W-1:0] ACTIVITY_MIN = 12'd10;
  localparam logic [CODE_W-1:0]   SCALE_MID    = 8'd127;
  localparam logic [CODE_W-1:0]   SCALE_TOP    = 8'd255;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LO       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_DEADBAND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BAND      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT    = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] steer;
    logic [SAMPLE_W-1:0] throttle;
  } sample_pair_t;

  typedef struct packed {
    logic shift;   // new sample enters the window row
    logic load;    // copy window into sort row
    logic sort;    // one compare-exchange round
  } cell_ctrl_t;

endpackage

@@ rtl/core/stcc_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: input samples, conditioned commands, register writes.
// Depends on stcc_pkg.
interface stcc_in_if;
  import stcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] steer_sample;
  logic [SAMPLE_W-1:0] throttle_sample;
  logic                light_request;
  modport source (output valid, steer_sample, throttle_sample, light_request, input ready);
  modport sink   (input valid, steer_sample, throttle_sample, light_request, output ready);
endinterface

interface stcc_out_if;
  import stcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] servo_pulse;
  logic [CODE_W-1:0] motor_duty;
  logic              drive_a;
  logic              drive_b;
  logic              light_out;
  logic              link_lost;
  modport source (output valid, servo_pulse, motor_duty, drive_a, drive_b, light_out,
                  link_lost, input ready);
  modport sink   (input valid, servo_pulse, motor_duty, drive_a, drive_b, light_out,
                  link_lost, output ready);
endinterface

interface stcc_cfg_if;
  import stcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/stcc_cell.sv @@
`timescale 1ns / 1ps
// One window cell: holds a steering/throttle entry and a sort slot that
// compare-exchanges with a neighbour. Depends on stcc_pkg.
module stcc_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  stcc_pkg::cell_ctrl_t  ctrl,
  input  logic                  pair_left,
  input  logic                  pair_right,
  input  stcc_pkg::sample_pair_t w_in,
  input  stcc_pkg::sample_pair_t s_left,
  input  stcc_pkg::sample_pair_t s_right,
  output stcc_pkg::sample_pair_t w_out,
  output stcc_pkg::sample_pair_t s_out
);
  import stcc_pkg::*;

  sample_pair_t w;
  sample_pair_t s;

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '{steer: SAMPLE_RESET, throttle: SAMPLE_RESET};
    end else if (ctrl.shift) begin
      w <= w_in;
    end
  end

  // right pairing keeps the smaller, left pairing the larger
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s <= w;
    end else if (ctrl.sort) begin
      if (pair_right) begin
        s.steer    <= (s_right.steer < s.steer) ? s_right.steer : s.steer;
        s.throttle <= (s_right.throttle < s.throttle) ? s_right.throttle : s.throttle;
      end else if (pair_left) begin
        s.steer    <= (s_left.steer > s.steer) ? s_left.steer : s.steer;
        s.throttle <= (s_left.throttle > s.throttle) ? s_left.throttle : s.throttle;
      end
    end
  end

  assign w_out = w;
  assign s_out = s;

endmodule

@@ rtl/core/stcc_scaler.sv @@
`timescale 1ns / 1ps
// Three-stage scaler: median * 255 / 4095, truncating, by reciprocal and
// one correction step. Depends on stcc_pkg.
module stcc_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [stcc_pkg::SAMPLE_W-1:0] median,
  output logic                          out_valid,
  output logic [stcc_pkg::CODE_W-1:0]   scaled
);
  import stcc_pkg::*;

  localparam int PROD_W = SAMPLE_W + CODE_W;   // median * 255
  localparam int RECIP_SHIFT = 24;             // 4097 / 2^24 just under 1/4095

  logic [2:0]        vld;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_d;
  logic [CODE_W-1:0] q0;
  logic [CODE_W-1:0] q_out;
  logic [31:0]       recip;
  logic [PROD_W:0]   rem;

  assign recip = {prod, 12'd0} + {12'd0, prod};
  // remainder of the estimate, at most one short
  assign rem   = {1'b0, prod_d} - {1'b0, q0, 12'd0} + {{(PROD_W+1-CODE_W){1'b0}}, q0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    prod   <= {median, 8'd0} - {8'd0, median};
    prod_d <= prod;
    q0     <= recip[RECIP_SHIFT +: CODE_W];
    q_out  <= (rem >= (PROD_W+1)'(4095)) ? q0 + 8'd1 : q0;
  end

  assign out_valid = vld[2];
  assign scaled    = q_out;

endmodule

@@ rtl/core/stcc_divider.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on stcc_pkg.
module stcc_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [stcc_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [stcc_pkg::DIV_DEN_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [stcc_pkg::DIV_NUM_W-1:0] quotient
);
  import stcc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/core/servo_throttle_command_conditioner_unit.sv @@
`timescale 1ns / 1ps
// Top level of the servo/throttle command conditioner.
// Depends on stcc_pkg, stcc_if, stcc_cell, stcc_scaler, stcc_divider.
//
// One input transaction (steering sample, throttle sample, light request)
// gives exactly one output transaction. The last WINDOW_DEPTH samples of each
// channel sit in a row of cells; on every transaction the row is copied and
// sorted by WINDOW_DEPTH rounds of neighbour compare-exchange, the upper
// median is scaled to 0..255, and a shared 16-bit divider works out the
// steering and throttle slopes one after the other. The next sample is
// taken only once the previous result sits in the output register, which
// holds it until the sink takes it. No link activity within the quiet limit
// (in transactions) puts out the safe state (centre pulse, motor off, light
// off, link_lost set). Register writes are accepted at any time but are meant
// for idle periods.
module servo_throttle_command_conditioner_unit (
  input  logic clk,
  input  logic rst,
  stcc_in_if.sink    in_ch,
  stcc_out_if.source out_ch,
  stcc_cfg_if.sink   cfg
);
  import stcc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LOAD   = 10'b00_0000_0010,
    ST_SORT   = 10'b00_0000_0100,
    ST_MEDIAN = 10'b00_0000_1000,
    ST_SCALE  = 10'b00_0001_0000,
    ST_PREP   = 10'b00_0010_0000,
    ST_DIVS   = 10'b00_0100_0000,
    ST_DIVM   = 10'b00_1000_0000,
    ST_TGT    = 10'b01_0000_0000,
    ST_FIN    = 10'b10_0000_0000
  } state_t;

  state_t state;

  // ---------------------------------------------------------------- config
  logic [CODE_W-1:0]    pulse_mid, pulse_lo, pulse_hi;
  logic [DB_W-1:0]      steer_deadband, stop_band;
  logic [CODE_W-1:0]    stop_code, min_power;
  logic [TIMEOUT_W-1:0] quiet_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_mid      <= 8'd94;
      pulse_lo       <= 8'd19;
      pulse_hi       <= 8'd200;
      steer_deadband <= 6'd5;
      stop_code      <= 8'd80;
      stop_band      <= 6'd10;
      min_power      <= 8'd120;
      quiet_limit    <= 20'd1000;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PULSE_MID:      pulse_mid      <= cfg.data[CODE_W-1:0];
        REG_PULSE_LO:       pulse_lo       <= cfg.data[CODE_W-1:0];
        REG_PULSE_HI:       pulse_hi       <= cfg.data[CODE_W-1:0];
        REG_STEER_DEADBAND: steer_deadband <= cfg.data[DB_W-1:0];
        REG_STOP_CODE:      stop_code      <= cfg.data[CODE_W-1:0];
        REG_STOP_BAND:      stop_band      <= cfg.data[DB_W-1:0];
        REG_MIN_POWER:      min_power      <= cfg.data[CODE_W-1:0];
        REG_QUIET_LIMIT:    quiet_limit    <= cfg.data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ activity tracking
  logic                in_acc;
  logic [SAMPLE_W-1:0] prior_steer, prior_throttle;
  logic [TICK_W-1:0]   tick_count, last_active;
  logic [TICK_W-1:0]   tick_next, last_next;
  logic [SAMPLE_W-1:0] steer_delta, throttle_delta;
  logic                moved;
  logic                active, light;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign steer_delta = (in_ch.steer_sample > prior_steer) ?
                       in_ch.steer_sample - prior_steer : prior_steer - in_ch.steer_sample;
  assign throttle_delta = (in_ch.throttle_sample > prior_throttle) ?
                          in_ch.throttle_sample - prior_throttle :
                          prior_throttle - in_ch.throttle_sample;
  assign moved     = (steer_delta > ACTIVITY_MIN) || (throttle_delta > ACTIVITY_MIN);
  assign tick_next = tick_count + 32'd1;
  assign last_next = moved ? tick_next : last_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_steer    <= SAMPLE_RESET;
      prior_throttle <= SAMPLE_RESET;
      tick_count     <= '0;
      last_active    <= '0;
      active         <= 1'b0;
      light          <= 1'b0;
    end else if (in_acc) begin
      prior_steer    <= in_ch.steer_sample;
      prior_throttle <= in_ch.throttle_sample;
      tick_count     <= tick_next;
      last_active    <= last_next;
      // wrap-around age of last activity against the quiet limit
      active <= (tick_next - last_next) <= {{(TICK_W-TIMEOUT_W){1'b0}}, quiet_limit};
      light  <= in_ch.light_request;
    end
  end

  // --------------------------------------------------------- window row
  cell_ctrl_t           cell_ctrl;
  logic [SORT_CNT_W-1:0] sort_cnt;
  sample_pair_t         w_row [WINDOW_DEPTH];
  sample_pair_t         s_row [WINDOW_DEPTH];
  sample_pair_t         new_pair;

  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.load  = (state == ST_LOAD);
  assign cell_ctrl.sort  = (state == ST_SORT);
  assign new_pair        = '{steer: in_ch.steer_sample, throttle: in_ch.throttle_sample};

  // Newest sample enters cell 0, oldest falls off the far end. Sorting
  // pairs (0,1),(2,3).. on even rounds and (1,2),(3,4).. on odd rounds.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic         pr, pl;
    sample_pair_t wi, sl, sr;
    if (i + 1 < WINDOW_DEPTH) begin : g_r
      assign pr = ((i % 2) == 1) ? sort_cnt[0] : ~sort_cnt[0];
      assign sr = s_row[i+1];
    end else begin : g_nr
      assign pr = 1'b0;
      assign sr = s_row[i];
    end
    if (i > 0) begin : g_l
      assign pl = ((i % 2) == 1) ? ~sort_cnt[0] : sort_cnt[0];
      assign sl = s_row[i-1];
      assign wi = w_row[i-1];
    end else begin : g_nl
      assign pl = 1'b0;
      assign sl = s_row[i];
      assign wi = new_pair;
    end
    stcc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .pair_left  (pl),
      .pair_right (pr),
      .w_in       (wi),
      .s_left     (sl),
      .s_right    (sr),
      .w_out      (w_row[i]),
      .s_out      (s_row[i])
    );
  end

  // ------------------------------------------------------------ scaling
  logic              sc_go, sc_s_vld, sc_t_vld;
  logic [CODE_W-1:0] sc_s, sc_t;
  logic [CODE_W-1:0] sv, tv;

  assign sc_go = (state == ST_MEDIAN);

  stcc_scaler u_scale_s (
    .clk (clk), .rst (rst), .in_valid (sc_go), .median (s_row[MEDIAN_IDX].steer),
    .out_valid (sc_s_vld), .scaled (sc_s)
  );
  stcc_scaler u_scale_t (
    .clk (clk), .rst (rst), .in_valid (sc_go), .median (s_row[MEDIAN_IDX].throttle),
    .out_valid (sc_t_vld), .scaled (sc_t)
  );

  // ------------------------------------------------------ slope set-up
  logic [CODE_W-1:0]    s_lo, s_hi, s_dist, s_mag, s_den;
  logic                 s_below_c, s_above_c, s_sub_c;
  logic [DIV_NUM_W-1:0] s_num;
  logic signed [9:0]    m_lo;
  logic [9:0]           m_hi;
  logic [CODE_W-1:0]    m_dist, m_span, m_den_c;
  logic                 m_below_c, m_above_c;
  logic [DIV_NUM_W-1:0] m_num_c;

  assign s_lo      = SCALE_MID - {2'b00, steer_deadband};
  assign s_hi      = SCALE_MID + {2'b00, steer_deadband};
  assign s_below_c = sv < s_lo;
  assign s_above_c = sv > s_hi;
  assign s_dist    = s_below_c ? s_lo - sv : sv - s_hi;
  assign s_mag     = s_below_c ?
                     ((pulse_mid >= pulse_lo) ? pulse_mid - pulse_lo
                                              : pulse_lo - pulse_mid) :
                     ((pulse_hi >= pulse_mid) ? pulse_hi - pulse_mid
                                              : pulse_mid - pulse_hi);
  // whether the quotient is taken off the centre value
  assign s_sub_c   = s_below_c ? (pulse_mid >= pulse_lo) : (pulse_hi < pulse_mid);
  assign s_num     = s_dist * s_mag;
  assign s_den     = s_below_c ? s_lo : SCALE_TOP - s_hi;

  assign m_lo      = $signed({2'b00, stop_code}) - $signed({4'b0000, stop_band});
  assign m_hi      = {2'b00, stop_code} + {4'b0000, stop_band};
  assign m_below_c = $signed({2'b00, tv}) < m_lo;
  assign m_above_c = {2'b00, tv} > m_hi;
  assign m_dist    = m_below_c ? m_lo[CODE_W-1:0] - tv : tv - m_hi[CODE_W-1:0];
  assign m_span    = SCALE_TOP - min_power;
  assign m_num_c   = m_dist * m_span;
  assign m_den_c   = m_below_c ? m_lo[CODE_W-1:0] : SCALE_TOP - m_hi[CODE_W-1:0];

  logic                 s_below, s_above, s_sub, m_below, m_above;
  logic [DIV_NUM_W-1:0] m_num;
  logic [CODE_W-1:0]    m_den;
  logic [DIV_NUM_W-1:0] q_s, q_m;

  // ---------------------------------------------------- shared divider
  logic                 div_start, div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  assign div_start = (state == ST_PREP) || ((state == ST_DIVS) && div_done);
  assign div_num   = (state == ST_PREP) ? s_num : m_num;
  assign div_den   = (state == ST_PREP) ? s_den : m_den;

  stcc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ------------------------------------------------ targets and output
  logic signed [11:0] s_c, s_off, s_raw, s_cl1, s_cl2;
  logic [CODE_W-1:0]  tgt, duty;
  logic               drv_a, drv_b;
  logic [16:0]        m_sum;
  logic [CODE_W-1:0]  smoothed;
  logic signed [8:0]  diff;
  logic signed [8:0]  step;
  logic [CODE_W-1:0]  new_sp;
  logic               out_free;

  assign s_c   = $signed({4'b0000, pulse_mid});
  assign s_off = $signed({1'b0, q_s[10:0]});
  assign s_raw = (!s_below && !s_above) ? s_c : (s_sub ? s_c - s_off : s_c + s_off);
  // raise to min first, then lower to max: max wins if the two cross
  assign s_cl1 = (s_raw < $signed({4'b0000, pulse_lo})) ? $signed({4'b0000, pulse_lo})
                                                        : s_raw;
  assign s_cl2 = (s_cl1 > $signed({4'b0000, pulse_hi})) ? $signed({4'b0000, pulse_hi})
                                                        : s_cl1;
  assign m_sum = {9'd0, min_power} + {1'b0, q_m};

  // quarter step toward target, rounding toward minus infinity
  assign diff   = $signed({1'b0, tgt}) - $signed({1'b0, smoothed});
  assign step   = diff >>> 2;
  assign new_sp = smoothed + step[CODE_W-1:0];

  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sort_cnt <= '0;
      smoothed <= 8'd94;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          sort_cnt <= '0;
          state    <= ST_SORT;
        end
        ST_SORT: begin
          sort_cnt <= sort_cnt + 1'b1;
          if (sort_cnt == SORT_CNT_W'(WINDOW_DEPTH - 1)) begin
            state <= ST_MEDIAN;
          end
        end
        ST_MEDIAN: state <= ST_SCALE;
        ST_SCALE: begin
          if (sc_s_vld && sc_t_vld) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_DIVS;
        ST_DIVS: begin
          if (div_done) begin
            state <= ST_DIVM;
          end
        end
        ST_DIVM: begin
          if (div_done) begin
            state <= ST_TGT;
          end
        end
        ST_TGT: state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            if (active) begin
              smoothed <= new_sp;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      sv <= sc_s;
      tv <= sc_t;
    end
    if (state == ST_PREP) begin
      s_below <= s_below_c;
      s_above <= s_above_c;
      s_sub   <= s_sub_c;
      m_below <= m_below_c;
      m_above <= m_above_c;
      m_num   <= m_num_c;
      m_den   <= m_den_c;
    end
    if ((state == ST_DIVS) && div_done) begin
      q_s <= div_quo;
    end
    if ((state == ST_DIVM) && div_done) begin
      q_m <= div_quo;
    end
    if (state == ST_TGT) begin
      tgt   <= s_cl2[CODE_W-1:0];
      drv_b <= m_below;
      drv_a <= m_above;
      if (!m_below && !m_above) begin
        duty <= '0;
      end else begin
        duty <= (m_sum > 17'd255) ? SCALE_TOP : m_sum[CODE_W-1:0];
      end
    end
    if ((state == ST_FIN) && out_free) begin
      if (active) begin
        out_ch.servo_pulse <= new_sp;
        out_ch.motor_duty  <= duty;
        out_ch.drive_a     <= drv_a;
        out_ch.drive_b     <= drv_b;
        out_ch.light_out   <= light;
        out_ch.link_lost   <= 1'b0;
      end else begin
        out_ch.servo_pulse <= pulse_mid;
        out_ch.motor_duty  <= '0;
        out_ch.drive_a     <= 1'b0;
        out_ch.drive_b     <= 1'b0;
        out_ch.light_out   <= 1'b0;
        out_ch.link_lost   <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------ checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the final step");

  a_safe_state: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.link_lost) |->
      (out_ch.motor_duty == '0) && !out_ch.drive_a && !out_ch.drive_b && !out_ch.light_out)
    else $error("safe state carries drive");

  a_bridge_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.drive_a && out_ch.drive_b))
    else $error("both bridge inputs high");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_LOAD))
    else $error("accepted transaction not loaded into sort row");

endmodule

@@ sim/stcc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the servo/throttle command conditioner: watches the sample, command and
// register channels, predicts each command and compares. Depends on stcc_pkg and stcc_if.
module stcc_checker (
  input  logic clk,
  input  logic rst,
  stcc_in_if  in_ch,
  stcc_out_if out_ch,
  stcc_cfg_if cfg,
  output int  fail_count,
  output int  pending_count
);
  import stcc_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] pulse;
    logic [CODE_W-1:0] duty;
    logic              drv_a;
    logic              drv_b;
    logic              light;
    logic              lost;
  } command_t;

  command_t command_q[$];

  logic [CODE_W-1:0]    centre_r, min_r, max_r, idle_r, power_r;
  logic [DB_W-1:0]      steer_db_r, thr_db_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  logic [SAMPLE_W-1:0] steer_win[WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] thr_win[WINDOW_DEPTH];
  int unsigned         slot;
  logic [SAMPLE_W-1:0] last_steer, last_thr;
  logic [CODE_W-1:0]   glide;
  logic [TICK_W-1:0]   ticks, active_tick;

  function automatic int unsigned median_code(logic [SAMPLE_W-1:0] w[WINDOW_DEPTH]);
    logic [SAMPLE_W-1:0] s[WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] t;
    s = w;
    for (int i = 0; i < WINDOW_DEPTH; i++)
      for (int j = 0; j < WINDOW_DEPTH - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    return (int'(s[MEDIAN_IDX]) * 255) / 4095;
  endfunction

  function automatic bit moved(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    return d > 10;
  endfunction

  // Advances the predicted state by one sample transaction, returns the command.
  function automatic command_t predict_command(logic [SAMPLE_W-1:0] st,
                                               logic [SAMPLE_W-1:0] th, logic lr);
    command_t c;
    int sv, tv, lo, hi, tgt, d, diff;
    ticks = ticks + 1;
    if (moved(st, last_steer) || moved(th, last_thr)) active_tick = ticks;
    last_steer = st;
    last_thr = th;
    steer_win[slot] = st;
    thr_win[slot] = th;
    slot = (slot + 1) % WINDOW_DEPTH;
    sv = median_code(steer_win);
    tv = median_code(thr_win);
    c = '0;
    if (ticks - active_tick > {12'd0, timeout_r}) begin
      c.pulse = centre_r;
      c.lost = 1'b1;
      return c;
    end
    lo = 127 - int'(steer_db_r);
    hi = 127 + int'(steer_db_r);
    if (sv >= lo && sv <= hi) tgt = centre_r;
    else if (sv < lo) tgt = int'(centre_r) - ((lo - sv) * (int'(centre_r) - int'(min_r))) / lo;
    else tgt = int'(centre_r) + ((sv - hi) * (int'(max_r) - int'(centre_r))) / (255 - hi);
    if (tgt < int'(min_r)) tgt = min_r;
    if (tgt > int'(max_r)) tgt = max_r;
    diff = tgt - int'(glide);
    diff = (diff >= 0) ? diff / 4 : -((-diff + 3) / 4);
    glide = 8'(int'(glide) + diff);
    c.pulse = glide;
    lo = int'(idle_r) - int'(thr_db_r);
    hi = int'(idle_r) + int'(thr_db_r);
    if (tv < lo || tv > hi) begin
      if (tv < lo) begin
        c.drv_b = 1'b1;
        d = int'(power_r) + ((lo - tv) * (255 - int'(power_r))) / lo;
      end else begin
        c.drv_a = 1'b1;
        d = int'(power_r) + ((tv - hi) * (255 - int'(power_r))) / (255 - hi);
      end
      if (d > 255) d = 255;
      if (d < 0) d = 0;
      c.duty = 8'(d);
    end
    c.light = lr;
    return c;
  endfunction

  always @(posedge clk) begin
    command_t got, want;
    if (rst) begin
      centre_r <= 8'd94; min_r <= 8'd19; max_r <= 8'd200; steer_db_r <= 6'd5;
      idle_r <= 8'd80; thr_db_r <= 6'd10; power_r <= 8'd120; timeout_r <= 20'd1000;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        steer_win[i] = SAMPLE_RESET;
        thr_win[i] = SAMPLE_RESET;
      end
      slot = 0;
      last_steer = SAMPLE_RESET;
      last_thr = SAMPLE_RESET;
      glide = 8'd94;
      ticks = '0;
      active_tick = '0;
      fail_count <= 0;
      command_q.delete();
      pending_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PULSE_MID:      centre_r <= cfg.data[7:0];
          REG_PULSE_LO:       min_r <= cfg.data[7:0];
          REG_PULSE_HI:       max_r <= cfg.data[7:0];
          REG_STEER_DEADBAND: steer_db_r <= cfg.data[5:0];
          REG_STOP_CODE:      idle_r <= cfg.data[7:0];
          REG_STOP_BAND:      thr_db_r <= cfg.data[5:0];
          REG_MIN_POWER:      power_r <= cfg.data[7:0];
          REG_QUIET_LIMIT:    timeout_r <= cfg.data[19:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        command_q.push_back(predict_command(in_ch.steer_sample, in_ch.throttle_sample,
                                            in_ch.light_request));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.servo_pulse, out_ch.motor_duty, out_ch.drive_a, out_ch.drive_b,
                out_ch.light_out, out_ch.link_lost};
        if (command_q.size() == 0) begin
          $display("%0t: unexpected command %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = command_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected pulse=%0d duty=%0d a=%b b=%b light=%b lost=%b",
                     $time, want.pulse, want.duty, want.drv_a, want.drv_b, want.light,
                     want.lost);
            $display("%0t:          actual   pulse=%0d duty=%0d a=%b b=%b light=%b lost=%b",
                     $time, got.pulse, got.duty, got.drv_a, got.drv_b, got.light, got.lost);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= command_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the conditioner regression: clock, reset, stimulus, receiver stalls and verdict.
// Depends on stcc_pkg, stcc_if, stcc_checker and the conditioner RTL.
module tb_top;
  import stcc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  bit   quiet = 1'b0;      // no idling in the final stretch
  bit   hold_off = 1'b0;   // long receiver stall request

  always #5 clk = ~clk;

  stcc_in_if  in_ch();
  stcc_out_if out_ch();
  stcc_cfg_if cfg();

  servo_throttle_command_conditioner_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  stcc_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Watchdog: the worst case of ~550 items, stalls included, is far under this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin
    int burst;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] st, logic [SAMPLE_W-1:0] th, logic lr);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.steer_sample <= st;
    in_ch.throttle_sample <= th;
    in_ch.light_request <= lr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Ends the current burst of samples, then waits until every predicted command
  // has been taken, plus the block's latency.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_setting(int centre, int lo, int hi, int sdb, int idle, int tdb,
                              int pwr, int tmo);
    write_reg(REG_PULSE_MID, CFG_DATA_W'(centre));
    write_reg(REG_PULSE_LO, CFG_DATA_W'(lo));
    write_reg(REG_PULSE_HI, CFG_DATA_W'(hi));
    write_reg(REG_STEER_DEADBAND, CFG_DATA_W'(sdb));
    write_reg(REG_STOP_CODE, CFG_DATA_W'(idle));
    write_reg(REG_STOP_BAND, CFG_DATA_W'(tdb));
    write_reg(REG_MIN_POWER, CFG_DATA_W'(pwr));
    write_reg(REG_QUIET_LIMIT, CFG_DATA_W'(tmo));
    cfg.valid <= 1'b0;
  endtask

  // Random run: mostly smooth stick sweeps, some jumps and single-bit steering flips,
  // and still stretches long enough to trip a short activity timeout.
  task automatic random_run(int n);
    logic [SAMPLE_W-1:0] st, th;
    st = 12'($urandom_range(0, 4095));
    th = 12'($urandom_range(0, 4095));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin st = 12'($urandom); th = 12'($urandom); end
        2:    ;  // held still
        3:    st = st ^ (12'd1 << $urandom_range(0, 11));
        default: begin
          st = 12'(int'(st) + $urandom_range(0, 160) - 80);
          th = 12'(int'(th) + $urandom_range(0, 160) - 80);
        end
      endcase
      send_sample(st, th, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.steer_sample = '0;
    in_ch.throttle_sample = '0;
    in_ch.light_request = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: sample extremes, deadband edges, both drive directions, lights.
    send_sample(12'd0, 12'd0, 1'b1);
    send_sample(12'hFFF, 12'hFFF, 1'b0);
    for (int i = 0; i < 8; i++) send_sample(12'hFFF, 12'd0, 1'b1);
    for (int i = 0; i < 6; i++) send_sample(12'd0, 12'hFFF, 1'b0);
    send_sample(12'd2048, 12'd1285, 1'b1);
    send_sample(12'd2038, 12'd1295, 1'b1);
    send_sample(12'hAAA, 12'h555, 1'b0);
    send_sample(12'h555, 12'hAAA, 1'b1);
    drain();

    // Crossed servo limits, widest deadbands, zero timeout, stop zone reaching down to 1.
    load_setting(255, 200, 19, 63, 64, 63, 255, 0);
    random_run(40);
    send_sample(12'd100, 12'd100, 1'b1);
    send_sample(12'd100, 12'd100, 1'b1);
    drain();

    // Zero steering deadband, widest stop band, zero power, stop zone to 254, short timeout.
    load_setting(0, 0, 255, 0, 191, 63, 0, 1);
    random_run(60);
    for (int i = 0; i < 5; i++) send_sample(12'd700, 12'd700, 1'b0);
    drain();

    // Long timeout; the receiver holds off while samples keep coming.
    load_setting(128, 10, 240, 20, 127, 0, 200, 20'hFFFFF);
    hold_off = 1'b1;
    random_run(30);
    drain();

    // Near-reset settings with a modest timeout so the safe state comes and goes.
    load_setting(94, 19, 200, 5, 80, 10, 120, 12);
    random_run(300);
    quiet = 1'b1;
    random_run(100);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
